/* src/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants of the SMTP reply line parser
// Holds the response record, the parser phase encoding and the byte codes.
// ----------------------------------------------------------------------------
package srp_pkg;

   // Request command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   // Accepted reply code range
   localparam logic [9:0] CODE_MIN = 10'd200;
   localparam logic [9:0] CODE_MAX = 10'd559;

   // Byte codes
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // Default depth of the response queue
   localparam int SRP_FIFO_DEPTH = 4;

   typedef enum logic [6:0] {
      PH_D1    = 7'b0000001,
      PH_D2    = 7'b0000010,
      PH_D3    = 7'b0000100,
      PH_SEP   = 7'b0001000,
      PH_TEXT  = 7'b0010000,
      PH_SEPCR = 7'b0100000,
      PH_HALT  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       text_valid;
      logic [7:0] text_char;
      logic       line_end;
      logic       more_lines;
      logic       reply_done;
      logic       reply_error;
      logic [9:0] reply_code;
      logic       last_of_run;
   } result_type;

endpackage

/* src/srp_req_if.sv */
// ----------------------------------------------------------------------------
// srp_req_if: request channel of the SMTP reply line parser
// Valid/ready channel carrying one command and one received byte.
// ----------------------------------------------------------------------------
interface srp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

/* src/srp_rsp_if.sv */
// ----------------------------------------------------------------------------
// srp_rsp_if: response channel of the SMTP reply line parser
// Valid/ready channel carrying one parsed text byte and the line status.
// ----------------------------------------------------------------------------
interface srp_rsp_if;
   logic       valid;
   logic       ready;
   logic       text_valid;
   logic [7:0] text_char;
   logic       line_end;
   logic       more_lines;
   logic       reply_done;
   logic       reply_error;
   logic [9:0] reply_code;
   logic       last_of_run;

   modport source (output valid, output text_valid, output text_char, output line_end,
                   output more_lines, output reply_done, output reply_error,
                   output reply_code, output last_of_run, input ready);
   modport sink   (input valid, input text_valid, input text_char, input line_end,
                   input more_lines, input reply_done, input reply_error,
                   input reply_code, input last_of_run, output ready);
endinterface

/* src/srp_parser.sv */
// ----------------------------------------------------------------------------
// srp_parser: reply line state machine
// Holds the parse state and works out the one or two responses of a request.
// ----------------------------------------------------------------------------
module srp_parser
   import srp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       cmd,
   input  logic [7:0] rx_byte,
   output result_type res0,
   output result_type res1,
   output logic       two_results
);

   phase_type  phase_ff, phase_in;
   logic [9:0] accum_ff, accum_in;
   logic [9:0] saved_ff, saved_in;
   logic       cont_ff, cont_in;
   logic       pcr_ff, pcr_in;
   logic       err_ff, err_in;
   logic       fin_ff, fin_in;

   logic        is_digit;
   logic [3:0]  digit;
   logic [9:0]  acc_base;
   logic [13:0] acc_sum;
   logic [9:0]  acc_new;
   logic        le, more, done, tv, first_cr;
   logic [7:0]  tc;

   assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign digit    = 4'(rx_byte - CH_ZERO);
   assign acc_base = (phase_ff == PH_D1) ? 10'd0 : accum_ff;
   // Times ten as two shifts
   assign acc_sum  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                   + {10'd0, digit};
   assign acc_new  = acc_sum[9:0];

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      saved_in = saved_ff;
      cont_in  = cont_ff;
      pcr_in   = pcr_ff;
      err_in   = err_ff;
      fin_in   = fin_ff;
      le       = 1'b0;
      more     = 1'b0;
      done     = 1'b0;
      tv       = 1'b0;
      tc       = 8'h00;
      first_cr = 1'b0;

      if (cmd == CMD_START) begin
         phase_in = PH_D1;
         accum_in = 10'd0;
         saved_in = 10'd0;
         cont_in  = 1'b0;
         pcr_in   = 1'b0;
         err_in   = 1'b0;
         fin_in   = 1'b0;
      end else if (!(err_ff || fin_ff || phase_ff == PH_HALT)) begin
         case (phase_ff)
            PH_D1, PH_D2: begin
               if (!is_digit) begin
                  err_in   = 1'b1;
                  phase_in = PH_HALT;
               end else begin
                  accum_in = acc_new;
                  phase_in = (phase_ff == PH_D1) ? PH_D2 : PH_D3;
               end
            end
            PH_D3: begin
               if (!is_digit) begin
                  err_in   = 1'b1;
                  phase_in = PH_HALT;
               end else begin
                  accum_in = acc_new;
                  if (acc_new < CODE_MIN || acc_new > CODE_MAX ||
                      (saved_ff != 10'd0 && saved_ff != acc_new)) begin
                     err_in   = 1'b1;
                     phase_in = PH_HALT;
                  end else begin
                     phase_in = PH_SEP;
                  end
               end
            end
            PH_SEP: begin
               if (rx_byte == CH_SP || rx_byte == CH_DASH || rx_byte == CH_CR) begin
                  saved_in = accum_ff;
                  cont_in  = (rx_byte == CH_DASH);
                  pcr_in   = 1'b0;
                  phase_in = (rx_byte == CH_CR) ? PH_SEPCR : PH_TEXT;
               end else begin
                  err_in   = 1'b1;
                  phase_in = PH_HALT;
               end
            end
            PH_SEPCR: begin
               if (rx_byte == CH_LF) begin
                  le = 1'b1;
               end else begin
                  // The CR was not a line end after all: it is dropped
                  phase_in = PH_TEXT;
                  if (rx_byte == CH_CR) begin
                     pcr_in = 1'b1;
                  end else begin
                     tv = 1'b1;
                     tc = rx_byte;
                  end
               end
            end
            PH_TEXT: begin
               if (pcr_ff) begin
                  if (rx_byte == CH_LF) begin
                     pcr_in = 1'b0;
                     le     = 1'b1;
                  end else begin
                     // The held CR goes out as text before this byte
                     first_cr = 1'b1;
                     if (rx_byte != CH_CR) begin
                        pcr_in = 1'b0;
                        tv     = 1'b1;
                        tc     = rx_byte;
                     end
                  end
               end else if (rx_byte == CH_CR) begin
                  pcr_in = 1'b1;
               end else begin
                  tv = 1'b1;
                  tc = rx_byte;
               end
            end
            default: begin
            end
         endcase

         if (le) begin
            more = cont_ff;
            if (cont_ff) begin
               phase_in = PH_D1;
            end else begin
               done     = 1'b1;
               fin_in   = 1'b1;
               phase_in = PH_HALT;
            end
         end
      end
   end

   always_comb begin
      res1.text_valid  = tv;
      res1.text_char   = tc;
      res1.line_end    = 1'b0;
      res1.more_lines  = 1'b0;
      res1.reply_done  = 1'b0;
      res1.reply_error = err_in;
      res1.reply_code  = saved_in;
      res1.last_of_run = 1'b1;

      if (first_cr) begin
         res0.text_valid  = 1'b1;
         res0.text_char   = CH_CR;
         res0.line_end    = 1'b0;
         res0.more_lines  = 1'b0;
         res0.reply_done  = 1'b0;
         res0.last_of_run = !tv;
      end else begin
         res0.text_valid  = tv;
         res0.text_char   = tc;
         res0.line_end    = le;
         res0.more_lines  = more;
         res0.reply_done  = done;
         res0.last_of_run = 1'b1;
      end
      res0.reply_error = err_in;
      res0.reply_code  = saved_in;
   end

   assign two_results = first_cr && tv;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_D1;
         accum_ff <= 10'd0;
         saved_ff <= 10'd0;
         cont_ff  <= 1'b0;
         pcr_ff   <= 1'b0;
         err_ff   <= 1'b0;
         fin_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         saved_ff <= saved_in;
         cont_ff  <= cont_in;
         pcr_ff   <= pcr_in;
         err_ff   <= err_in;
         fin_ff   <= fin_in;
      end
   end

   a_two_only_after_cr: assert property (@(posedge clock) disable iff (reset)
      two_results |-> (phase_ff == PH_TEXT) && pcr_ff && (cmd == CMD_BYTE))
      else $error("two responses outside a held CR in text");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (step && cmd == CMD_BYTE && err_ff) |=> err_ff)
      else $error("error flag dropped without a start request");

endmodule

/* src/srp_result_fifo.sv */
// ----------------------------------------------------------------------------
// srp_result_fifo: response queue
// Takes one or two responses per cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
module srp_result_fifo
   import srp_pkg::*;
#(
   parameter int Depth = SRP_FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       push_two,
   input  result_type data0,
   input  result_type data1,
   output logic       has_room,
   srp_rsp_if.source  rsp_bus
);

   localparam int PtrW = (Depth > 2) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   result_type mem_ff [Depth];

   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW-1:0] wr_next, wr_next2, rd_next;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] add_n;
   logic            pop;
   result_type      head;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_next  = ptr_inc(wr_ff);
   assign wr_next2 = ptr_inc(wr_next);
   assign rd_next  = ptr_inc(rd_ff);

   assign head     = mem_ff[rd_ff];
   assign pop      = rsp_bus.valid && rsp_bus.ready;
   // Room for a two-response request, whatever leaves this cycle
   assign has_room = count_ff <= CntW'(Depth - 2);

   assign add_n    = push ? (push_two ? CntW'(2) : CntW'(1)) : '0;
   assign count_in = count_ff + add_n - CntW'(pop);
   assign wr_in    = push ? (push_two ? wr_next2 : wr_next) : wr_ff;
   assign rd_in    = pop ? rd_next : rd_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= data0;
      end
      if (push && push_two) begin
         mem_ff[wr_next] <= data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   assign rsp_bus.valid       = count_ff != '0;
   assign rsp_bus.text_valid  = head.text_valid;
   assign rsp_bus.text_char   = head.text_char;
   assign rsp_bus.line_end    = head.line_end;
   assign rsp_bus.more_lines  = head.more_lines;
   assign rsp_bus.reply_done  = head.reply_done;
   assign rsp_bus.reply_error = head.reply_error;
   assign rsp_bus.reply_code  = head.reply_code;
   assign rsp_bus.last_of_run = head.last_of_run;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("response queue holds more than its depth");

   a_push_with_room: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff <= CntW'(Depth - 2))
      else $error("response pushed without room for two");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (count_ff == '0) && !rsp_bus.valid)
      else $error("response queue not empty after reset");

endmodule

/* src/smtp_reply_line_parser.sv */
// ----------------------------------------------------------------------------
// smtp_reply_line_parser: SMTP reply line parser, top level
// Request register, reply line state machine and response queue.
// ----------------------------------------------------------------------------
// Each request is a start command or one received byte; the block takes one
// request per clock while the queue has room. A request is held in an input
// register and parsed once the queue has room for its responses, which then
// enter a queue of FifoDepth entries and are offered from there.
// Most requests give one response. A byte in the text that follows a held
// CR and is neither CR nor LF gives two (the CR, then the byte); as the
// queue hands out one response per cycle while the sink is ready, such a
// request takes an extra slot of output bandwidth. The request side
// stalls only while the queue has room for fewer than two responses. The
// last response of each request carries last_of_run.
module smtp_reply_line_parser
   import srp_pkg::*;
#(
   parameter int FifoDepth = SRP_FIFO_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   srp_req_if.sink   req_bus,
   srp_rsp_if.source rsp_bus
);

   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       accept;
   logic       step;
   logic       has_room;
   logic       two_results;
   result_type res0, res1;

   assign step          = in_valid_ff && has_room;
   assign req_bus.ready = !in_valid_ff || step;
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_valid_in   = accept ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= req_bus.cmd;
         in_byte_ff <= req_bus.rx_byte;
      end
   end

   srp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cmd         (in_cmd_ff),
      .rx_byte     (in_byte_ff),
      .res0        (res0),
      .res1        (res1),
      .two_results (two_results)
   );

   srp_result_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (step),
      .push_two (two_results),
      .data0    (res0),
      .data1    (res1),
      .has_room (has_room),
      .rsp_bus  (rsp_bus)
   );

endmodule
